>>> design/lkr_pkg.sv
package lkr_pkg;

   localparam int FRAME_COUNT = 64;

   localparam logic [1:0] CMD_ACCESS = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_EVICT  = 2'd3;

   localparam logic [0:0] REG_K_DEPTH       = 1'b0;
   localparam logic [0:0] REG_FRAMES_IN_USE = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] frame_sel;
      logic       evictable_flag;
   } req_type;

   typedef struct packed {
      logic       evict_found;
      logic [5:0] evicted_frame;
      logic [6:0] evictable_count;
      logic       error_flag;
   } rsp_type;

endpackage

>>> design/lru_k_frame_replacer_top.sv
// Access, set and remove pass through the EXEC and OUT states before the result is valid.
// Evict goes through EXEC, SCAN, DONE and OUT, with one history memory read per frame, pipelined
// through a single shared compare unit that keeps the running minimum key.
// One transaction is processed at a time and req_stall is high while it runs; a finished
// result waits in the output register while the next transaction is processed.
// Reset is synchronous: all frames become untracked, counters and config go to defaults.
module lru_k_frame_replacer_top
   import lkr_pkg::*;
#(
   parameter int MAX_K       = 8,
   parameter int STAMP_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int FW = $clog2(FRAME_COUNT);
   localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CW = $clog2(MAX_K + 1);
   localparam int NW = $clog2(FRAME_COUNT + 1);
   localparam int HD = FRAME_COUNT * MAX_K;
   localparam int HW = $clog2(HD);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [3:0] k_depth_ff;
   logic [6:0] frames_in_use_ff;

   logic [FRAME_COUNT-1:0] valid_ff, evict_ff;
   logic [CW-1:0] count_ff [FRAME_COUNT];
   logic [KW-1:0] ptr_ff [FRAME_COUNT];
   logic [STAMP_WIDTH-1:0] hist_mem [HD];
   logic [STAMP_WIDTH-1:0] rd_ff;
   logic [STAMP_WIDTH-1:0] stamp_ff;
   logic [NW-1:0] total_ff;

   logic [2:0] state_ff;
   req_type req_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic found_ff;
   logic [5:0] victim_ff;
   logic err_ff;

   logic [FW:0] scan_ff;
   logic p1_ff, p1_cls_ff;
   logic [FW-1:0] p1_id_ff;
   logic have_ff, best_cls_ff;
   logic [FW-1:0] best_ff;
   logic [STAMP_WIDTH-1:0] best_st_ff;

   logic [CW-1:0] keff;
   logic wr_cfg;
   logic [FW-1:0] fid;
   logic fid_ok;
   logic exec_err;
   logic [STAMP_WIDTH-1:0] stamp_in;
   logic [FW-1:0] sid;
   logic s_cls;
   logic [KW-1:0] s_idx;
   logic [KW:0] s_sum;
   logic better;

   assign pready    = 1'b1;
   assign wr_cfg    = psel && penable && pwrite;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      unique case (paddr[2])
         REG_K_DEPTH:       prdata = {28'd0, k_depth_ff};
         REG_FRAMES_IN_USE: prdata = {25'd0, frames_in_use_ff};
         default:           prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (k_depth_ff == 4'd0) keff = CW'(1);
      else if (32'(k_depth_ff) > MAX_K) keff = CW'(MAX_K);
      else keff = CW'(k_depth_ff);
   end

   assign fid    = FW'(req_ff.frame_sel);
   assign fid_ok = (7'(req_ff.frame_sel) < frames_in_use_ff)
                   && (32'(req_ff.frame_sel) < FRAME_COUNT);
   assign exec_err = !fid_ok
                     || (req_ff.cmd == CMD_REMOVE && valid_ff[fid] && !evict_ff[fid]);
   assign stamp_in = (stamp_ff != '1) ? stamp_ff + 1'b1 : stamp_ff;

   assign sid   = scan_ff[FW-1:0];
   assign s_cls = (count_ff[sid] >= keff);
   assign s_sum = (KW+1)'(ptr_ff[sid]) + (KW+1)'(MAX_K) - (KW+1)'(keff);
   assign s_idx = (32'(s_sum) >= MAX_K) ? KW'(32'(s_sum) - MAX_K) : KW'(s_sum);

   assign better = !have_ff || (p1_cls_ff < best_cls_ff)
                   || ((p1_cls_ff == best_cls_ff) && (rd_ff < best_st_ff));

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && req_ff.cmd == CMD_ACCESS && fid_ok) begin
         hist_mem[HW'(fid) * HW'(MAX_K) + HW'(valid_ff[fid] ? ptr_ff[fid] : '0)]
            <= stamp_in;
      end
      rd_ff <= hist_mem[HW'(sid) * HW'(MAX_K) + HW'(s_cls ? s_idx : '0)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_depth_ff       <= 4'd2;
         frames_in_use_ff <= 7'd64;
         valid_ff         <= '0;
         evict_ff         <= '0;
         stamp_ff         <= '0;
         total_ff         <= '0;
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         scan_ff          <= '0;
         p1_ff            <= 1'b0;
         have_ff          <= 1'b0;
         for (int i = 0; i < FRAME_COUNT; i++) begin
            count_ff[i] <= '0;
            ptr_ff[i]   <= '0;
         end
      end else begin
         if (wr_cfg) begin
            if (paddr[2] == REG_K_DEPTH) k_depth_ff <= pwdata[3:0];
            else frames_in_use_ff <= pwdata[6:0];
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               found_ff  <= 1'b0;
               victim_ff <= '0;
               err_ff    <= (req_ff.cmd != CMD_EVICT) && exec_err;
               if (req_ff.cmd == CMD_EVICT) begin
                  scan_ff  <= '0;
                  p1_ff    <= 1'b0;
                  have_ff  <= 1'b0;
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_OUT;
                  if (fid_ok && req_ff.cmd == CMD_ACCESS) begin
                     stamp_ff <= stamp_in;
                     if (!valid_ff[fid]) begin
                        valid_ff[fid] <= 1'b1;
                        evict_ff[fid] <= 1'b1;
                        total_ff      <= total_ff + 1'b1;
                        count_ff[fid] <= CW'(1);
                        ptr_ff[fid]   <= (MAX_K > 1) ? KW'(1) : '0;
                     end else begin
                        if (32'(count_ff[fid]) < MAX_K) count_ff[fid] <= count_ff[fid] + 1'b1;
                        ptr_ff[fid] <= (32'(ptr_ff[fid]) + 1 >= MAX_K) ? '0
                                       : ptr_ff[fid] + 1'b1;
                     end
                  end else if (fid_ok && req_ff.cmd == CMD_SET) begin
                     if (valid_ff[fid]) begin
                        if (evict_ff[fid] && !req_ff.evictable_flag && total_ff != '0)
                           total_ff <= total_ff - 1'b1;
                        else if (!evict_ff[fid] && req_ff.evictable_flag)
                           total_ff <= total_ff + 1'b1;
                        evict_ff[fid] <= req_ff.evictable_flag;
                     end
                  end else if (fid_ok && valid_ff[fid] && evict_ff[fid]) begin
                     valid_ff[fid] <= 1'b0;
                     evict_ff[fid] <= 1'b0;
                     count_ff[fid] <= '0;
                     ptr_ff[fid]   <= '0;
                     if (total_ff != '0) total_ff <= total_ff - 1'b1;
                  end
               end
            end
            ST_SCAN: begin
               p1_ff     <= valid_ff[sid] && evict_ff[sid];
               p1_cls_ff <= s_cls;
               p1_id_ff  <= sid;
               if (p1_ff && better) begin
                  have_ff     <= 1'b1;
                  best_ff     <= p1_id_ff;
                  best_cls_ff <= p1_cls_ff;
                  best_st_ff  <= rd_ff;
               end
               scan_ff <= scan_ff + 1'b1;
               if (32'(scan_ff) == FRAME_COUNT - 1) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (p1_ff && better) begin
                  found_ff             <= 1'b1;
                  victim_ff            <= 6'(p1_id_ff);
                  valid_ff[p1_id_ff]   <= 1'b0;
                  evict_ff[p1_id_ff]   <= 1'b0;
                  count_ff[p1_id_ff]   <= '0;
                  ptr_ff[p1_id_ff]     <= '0;
                  if (total_ff != '0) total_ff <= total_ff - 1'b1;
               end else if (have_ff) begin
                  found_ff             <= 1'b1;
                  victim_ff            <= 6'(best_ff);
                  valid_ff[best_ff]    <= 1'b0;
                  evict_ff[best_ff]    <= 1'b0;
                  count_ff[best_ff]    <= '0;
                  ptr_ff[best_ff]      <= '0;
                  if (total_ff != '0) total_ff <= total_ff - 1'b1;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_ff       <= {found_ff, victim_ff, 7'(total_ff), err_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= FRAME_COUNT)
      else $error("evictable total out of range");
   assert property (@(posedge clock) disable iff (reset)
      (evict_ff & ~valid_ff) == '0)
      else $error("untracked frame marked evictable");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff != ST_SCAN && state_ff != ST_DONE) || !rsp_ff.error_flag
         || !rsp_ff.evict_found)
      else $error("evict result carries error");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_valid_ff) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not presented");

endmodule

>>> verif/tb_lru_k_frame_replacer_top.sv
module tb_lru_k_frame_replacer_top;
   import lkr_pkg::*;

   localparam int FRAMES      = 64;
   localparam int DEPTH       = 8;
   localparam int STALL_LIMIT = 3000;

   class replacer_scoreboard;
      bit           tracked   [FRAMES];
      bit           unpinned  [FRAMES];
      logic [3:0]   hits      [FRAMES];
      logic [31:0]  stamps    [FRAMES][DEPTH];
      logic [2:0]   slot      [FRAMES];
      logic [31:0]  clock_stamp;
      logic [6:0]   unpinned_total;
      logic [3:0]   k_setting;
      logic [6:0]   frame_limit;
      rsp_type      pending_rsp [$];
      int           mismatches;

      function new();
         foreach (tracked[f]) begin
            tracked[f]  = 0;
            unpinned[f] = 0;
            hits[f]     = 0;
            slot[f]     = 0;
            foreach (stamps[f][d]) stamps[f][d] = 0;
         end
         clock_stamp    = 0;
         unpinned_total = 0;
         k_setting      = 2;
         frame_limit    = 64;
         mismatches     = 0;
      endfunction

      function void untrack(int f);
         tracked[f]  = 0;
         unpinned[f] = 0;
         hits[f]     = 0;
         slot[f]     = 0;
         if (unpinned_total > 0) unpinned_total--;
      endfunction

      function void note_request(req_type r);
         rsp_type    e;
         int         f;
         int         k;
         int         idx;
         bit         have;
         int         best;
         int         best_cls;
         logic [31:0] best_stamp;
         int         cls;
         logic [31:0] st;
         e = '0;
         f = r.frame_sel;
         if (r.cmd == CMD_EVICT) begin
            k = (k_setting == 0) ? 1 : ((k_setting > DEPTH) ? DEPTH : k_setting);
            have = 0;
            best = 0;
            best_cls = 0;
            best_stamp = 0;
            for (int i = 0; i < FRAMES; i++) begin
               if (tracked[i] && unpinned[i]) begin
                  if (hits[i] < k) begin
                     cls = 0;
                     st = stamps[i][0];
                  end else begin
                     idx = (slot[i] + DEPTH - k) % DEPTH;
                     cls = 1;
                     st = stamps[i][idx];
                  end
                  if (!have || cls < best_cls || (cls == best_cls && st < best_stamp)) begin
                     have = 1;
                     best = i;
                     best_cls = cls;
                     best_stamp = st;
                  end
               end
            end
            if (have) begin
               untrack(best);
               e.evict_found = 1'b1;
               e.evicted_frame = 6'(best);
            end
         end else if (f >= frame_limit) begin
            e.error_flag = 1'b1;
         end else if (r.cmd == CMD_ACCESS) begin
            if (!tracked[f]) begin
               tracked[f]  = 1;
               unpinned[f] = 1;
               hits[f]     = 0;
               slot[f]     = 0;
               unpinned_total++;
            end
            if (clock_stamp != 32'hFFFF_FFFF) clock_stamp++;
            stamps[f][slot[f]] = clock_stamp;
            slot[f] = 3'(slot[f] + 1);
            if (hits[f] < DEPTH) hits[f]++;
         end else if (r.cmd == CMD_SET) begin
            if (tracked[f]) begin
               if (unpinned[f] && !r.evictable_flag) begin
                  if (unpinned_total > 0) unpinned_total--;
               end else if (!unpinned[f] && r.evictable_flag) begin
                  unpinned_total++;
               end
               unpinned[f] = r.evictable_flag;
            end
         end else begin
            if (tracked[f]) begin
               if (!unpinned[f]) e.error_flag = 1'b1;
               else untrack(f);
            end
         end
         e.evictable_count = unpinned_total;
         pending_rsp = {pending_rsp, e};
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction on result side: %p", a);
            return;
         end
         e = pending_rsp.pop_front();
         if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", e, a);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   replacer_scoreboard sb = new();
   bit quiet;
   bit hold_req;
   int hold_left;
   int idle_cycles;

   lru_k_frame_replacer_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("** lru_k_frame_replacer_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      hold_left = 0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1;
            hold_left--;
         end else if (hold_req) begin
            hold_req = 0;
            hold_left = 300;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 30);
         end
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [5:0] fid, logic flag);
      req_type r;
      r.cmd = cmd;
      r.frame_sel = fid;
      r.evictable_flag = flag;
      while (!quiet && $urandom_range(99) < 30) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      req_valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      if (addr == 3'd0) sb.k_setting = value[3:0];
      else sb.frame_limit = value[6:0];
   endtask

   task automatic random_items(int count);
      int roll;
      logic [5:0] fid;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if ($urandom_range(99) < 85 && sb.frame_limit > 0)
            fid = 6'($urandom_range(((sb.frame_limit > 64) ? 64 : sb.frame_limit) - 1));
         else
            fid = 6'($urandom_range(63));
         if (roll < 45) send_item(CMD_ACCESS, fid, 1'($urandom_range(1)));
         else if (roll < 65) send_item(CMD_SET, fid, 1'($urandom_range(1)));
         else if (roll < 80) send_item(CMD_REMOVE, fid, 1'($urandom_range(1)));
         else send_item(CMD_EVICT, 6'($urandom_range(63)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int k_list [8] = '{1, 8, 0, 15, 3, 4, 5, 2};
      int f_list [8] = '{64, 64, 16, 64, 1, 0, 100, 64};
      reset = 1;
      req_valid = 0;
      req_data = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      quiet = 0;
      hold_req = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(CMD_EVICT, 6'd0, 1'b0);
      send_item(CMD_ACCESS, 6'd0, 1'b0);
      send_item(CMD_ACCESS, 6'd63, 1'b1);
      send_item(CMD_ACCESS, 6'd0, 1'b0);
      send_item(CMD_SET, 6'd0, 1'b0);
      send_item(CMD_ACCESS, 6'd0, 1'b1);
      send_item(CMD_REMOVE, 6'd0, 1'b0);
      send_item(CMD_REMOVE, 6'd5, 1'b1);
      send_item(CMD_SET, 6'd5, 1'b1);
      send_item(CMD_SET, 6'd63, 1'b1);
      send_item(CMD_ACCESS, 6'd7, 1'b0);
      send_item(CMD_ACCESS, 6'd7, 1'b0);
      send_item(CMD_EVICT, 6'd63, 1'b1);
      send_item(CMD_SET, 6'd0, 1'b1);
      send_item(CMD_EVICT, 6'd0, 1'b0);
      send_item(CMD_EVICT, 6'd0, 1'b0);
      send_item(CMD_EVICT, 6'd0, 1'b0);
      send_item(CMD_ACCESS, 6'd9, 1'b0);
      send_item(CMD_REMOVE, 6'd9, 1'b0);
      random_items(110);

      for (int p = 0; p < 8; p++) begin
         write_csr(3'd0, k_list[p]);
         write_csr(3'd4, f_list[p]);
         quiet = (p == 3);
         if (p == 1) hold_req = 1;
         random_items(110);
      end
      quiet = 0;

      req_valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("** lru_k_frame_replacer_top: PASSED **");
      end else begin
         $display("** lru_k_frame_replacer_top: FAILED **");
      end
      $finish;
   end

endmodule
